// File: rtl/psd_pkg.sv
package psd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEG_START_X = 3'd0,
        CFG_SEG_START_Y = 3'd1,
        CFG_SEG_END_X   = 3'd2,
        CFG_SEG_END_Y   = 3'd3
    } t_cfg_reg;

endpackage

// File: rtl/psd_in_if.sv
interface psd_in_if
    import psd_pkg::*;
#(parameter int COORD_BITS = COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: rtl/psd_out_if.sv
interface psd_out_if
    import psd_pkg::*;
#(parameter int COORD_BITS = COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic        [COORD_BITS:0]   dist_out;
    logic        [COORD_BITS:0]   seg_length;
    logic signed [COORD_BITS-1:0] mid_x;
    logic signed [COORD_BITS-1:0] mid_y;

    modport source (output valid, output dist_out, output seg_length, output mid_x,
                    output mid_y, input ready);
    modport sink   (input valid, input dist_out, input seg_length, input mid_x,
                    input mid_y, output ready);
endinterface

// File: rtl/psd_prep.sv
module psd_prep
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic [3:0]                     i_en,
    input  logic signed [COORD_BITS-1:0]   i_px,
    input  logic signed [COORD_BITS-1:0]   i_py,
    input  logic signed [COORD_BITS-1:0]   i_sx,
    input  logic signed [COORD_BITS-1:0]   i_sy,
    input  logic signed [COORD_BITS-1:0]   i_ex,
    input  logic signed [COORD_BITS-1:0]   i_ey,
    output logic [4*COORD_BITS+1:0]        o_rhs,
    output logic [2*COORD_BITS:0]          o_len2,
    output logic [2*COORD_BITS:0]          o_ab2
);
    localparam int DFW = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;
    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int PW  = 2 * DFW;
    localparam int RW  = 2 * LW;

    logic signed [DFW-1:0] abx, aby;
    logic signed [DFW-1:0] r_apx, r_apy, r_bpx, r_bpy;
    logic signed [DFW-1:0] n_apx, n_apy, n_bpx, n_bpy;
    logic signed [PW-1:0]  m_apx, m_apy, m_bpx, m_bpy, m_abx, m_aby, m_c1, m_c2;
    logic [SQW-1:0]        r_sq_apx, r_sq_apy, r_sq_bpx, r_sq_bpy, r_sq_abx, r_sq_aby;
    logic signed [LW-1:0]  r_c1, r_c2;
    logic [LW-1:0]         r_pa2, r_pb2, r_ab2, r_abscr;
    logic signed [LW:0]    cr;
    logic [LW:0]           sum_a, sum_b;
    logic [RW-1:0]         crsq;
    logic                  near_a, near_b;

    assign abx   = DFW'(i_ex) - DFW'(i_sx);
    assign aby   = DFW'(i_ey) - DFW'(i_sy);
    assign n_apx = DFW'(i_px) - DFW'(i_sx);
    assign n_apy = DFW'(i_py) - DFW'(i_sy);
    assign n_bpx = DFW'(i_px) - DFW'(i_ex);
    assign n_bpy = DFW'(i_py) - DFW'(i_ey);

    assign m_apx = PW'(r_apx) * PW'(r_apx);
    assign m_apy = PW'(r_apy) * PW'(r_apy);
    assign m_bpx = PW'(r_bpx) * PW'(r_bpx);
    assign m_bpy = PW'(r_bpy) * PW'(r_bpy);
    assign m_abx = PW'(abx) * PW'(abx);
    assign m_aby = PW'(aby) * PW'(aby);
    assign m_c1  = PW'(abx) * PW'(r_apy);
    assign m_c2  = PW'(aby) * PW'(r_apx);

    assign cr    = (LW+1)'(r_c1) - (LW+1)'(r_c2);
    assign sum_a = (LW+1)'(r_pa2) + (LW+1)'(r_ab2);
    assign sum_b = (LW+1)'(r_pb2) + (LW+1)'(r_ab2);
    assign near_a = (LW+1)'(r_pb2) >= sum_a;
    assign near_b = (LW+1)'(r_pa2) >= sum_b;
    assign crsq  = RW'(r_abscr) * RW'(r_abscr);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_apx <= n_apx;
            r_apy <= n_apy;
            r_bpx <= n_bpx;
            r_bpy <= n_bpy;
        end
        if (i_en[1]) begin
            r_sq_apx <= m_apx[SQW-1:0];
            r_sq_apy <= m_apy[SQW-1:0];
            r_sq_bpx <= m_bpx[SQW-1:0];
            r_sq_bpy <= m_bpy[SQW-1:0];
            r_sq_abx <= m_abx[SQW-1:0];
            r_sq_aby <= m_aby[SQW-1:0];
            r_c1     <= m_c1[LW-1:0];
            r_c2     <= m_c2[LW-1:0];
        end
        if (i_en[2]) begin
            r_pa2   <= LW'(r_sq_apx) + LW'(r_sq_apy);
            r_pb2   <= LW'(r_sq_bpx) + LW'(r_sq_bpy);
            r_ab2   <= LW'(r_sq_abx) + LW'(r_sq_aby);
            r_abscr <= cr[LW] ? LW'(-cr) : cr[LW-1:0];
        end
        if (i_en[3]) begin
            o_ab2 <= r_ab2;
            if (near_a) begin
                o_rhs  <= RW'(r_pa2);
                o_len2 <= LW'(1);
            end else if (near_b) begin
                o_rhs  <= RW'(r_pb2);
                o_len2 <= LW'(1);
            end else begin
                o_rhs  <= crsq;
                o_len2 <= r_ab2;
            end
        end
    end
endmodule

// File: rtl/psd_cell.sv
module psd_cell
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BIT        = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [4*COORD_BITS+1:0]   i_rem,
    input  logic [3*COORD_BITS+1:0]   i_dl,
    input  logic [COORD_BITS:0]       i_d,
    input  logic [2*COORD_BITS:0]     i_len2,
    input  logic [2*COORD_BITS:0]     i_rem2,
    input  logic [COORD_BITS:0]       i_s,
    output logic [4*COORD_BITS+1:0]   o_rem,
    output logic [3*COORD_BITS+1:0]   o_dl,
    output logic [COORD_BITS:0]       o_d,
    output logic [2*COORD_BITS:0]     o_len2,
    output logic [2*COORD_BITS:0]     o_rem2,
    output logic [COORD_BITS:0]       o_s
);
    localparam int DW  = COORD_BITS + 1;
    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int RW  = 2 * LW;
    localparam int DLW = DW + LW;
    localparam int TW  = RW + 2;

    logic [TW-1:0] t_a, t_b;
    logic          take_a, take_b;

    // trial term for setting this bit: 2*d*L*2^b + L*2^2b
    assign t_a    = (TW'(i_dl) << (BIT + 1)) + (TW'(i_len2) << (2 * BIT));
    assign take_a = t_a <= TW'(i_rem);
    assign t_b    = (TW'(i_s) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign take_b = t_b <= TW'(i_rem2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len2 <= i_len2;
            if (take_a) begin
                o_rem <= i_rem - t_a[RW-1:0];
                o_dl  <= i_dl + (DLW'(i_len2) << BIT);
                o_d   <= i_d | (DW'(1) << BIT);
            end else begin
                o_rem <= i_rem;
                o_dl  <= i_dl;
                o_d   <= i_d;
            end
            if (take_b) begin
                o_rem2 <= i_rem2 - t_b[LW-1:0];
                o_s    <= i_s | (DW'(1) << BIT);
            end else begin
                o_rem2 <= i_rem2;
                o_s    <= i_s;
            end
        end
    end
endmodule

// File: rtl/point_segment_distance.sv
// channel | dir | fields
// i_pt    | in  | point_x, point_y
// o_res   | out | dist_out, seg_length, mid_x, mid_y
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// One beat per cycle unless o_res stalls a full pipeline; four set-up stages
// (differences, products, sums, branch select and cross squared), then one
// root cell per result bit. Synchronous reset clears the valid bits and the
// segment registers. A stall at o_res holds only the stages that are full.
module point_segment_distance
    import psd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]    i_cfg_data,
    psd_in_if.sink                   i_pt,
    psd_out_if.source                o_res
);
    localparam int DW  = COORD_BITS + 1;
    localparam int LW  = 2 * COORD_BITS + 1;
    localparam int RW  = 2 * LW;
    localparam int DLW = DW + LW;
    localparam int NP  = 4;
    localparam int NS  = NP + DW;

    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    logic [RW-1:0]  c_rem  [DW+1];
    logic [DLW-1:0] c_dl   [DW+1];
    logic [DW-1:0]  c_d    [DW+1];
    logic [LW-1:0]  c_len2 [DW+1];
    logic [LW-1:0]  c_rem2 [DW+1];
    logic [DW-1:0]  c_s    [DW+1];

    logic signed [COORD_BITS:0] sum_x, sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SEG_START_X: r_sx <= i_cfg_data;
                CFG_SEG_START_Y: r_sy <= i_cfg_data;
                CFG_SEG_END_X:   r_ex <= i_cfg_data;
                CFG_SEG_END_Y:   r_ey <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        en[NS] = o_res.ready;
        for (int i = NS - 1; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_pt.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign i_pt.ready = en[0];

    psd_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .i_clk  (i_clk),
        .i_en   (en[NP-1:0]),
        .i_px   (i_pt.point_x),
        .i_py   (i_pt.point_y),
        .i_sx   (r_sx),
        .i_sy   (r_sy),
        .i_ex   (r_ex),
        .i_ey   (r_ey),
        .o_rhs  (c_rem[0]),
        .o_len2 (c_len2[0]),
        .o_ab2  (c_rem2[0])
    );

    assign c_dl[0] = '0;
    assign c_d[0]  = '0;
    assign c_s[0]  = '0;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        psd_cell #(.COORD_BITS(COORD_BITS), .BIT(DW - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en[NP+k]),
            .i_rem  (c_rem[k]),
            .i_dl   (c_dl[k]),
            .i_d    (c_d[k]),
            .i_len2 (c_len2[k]),
            .i_rem2 (c_rem2[k]),
            .i_s    (c_s[k]),
            .o_rem  (c_rem[k+1]),
            .o_dl   (c_dl[k+1]),
            .o_d    (c_d[k+1]),
            .o_len2 (c_len2[k+1]),
            .o_rem2 (c_rem2[k+1]),
            .o_s    (c_s[k+1])
        );
    end

    assign sum_x = (COORD_BITS+1)'(r_sx) + (COORD_BITS+1)'(r_ex);
    assign sum_y = (COORD_BITS+1)'(r_sy) + (COORD_BITS+1)'(r_ey);

    assign o_res.valid      = r_v[NS-1];
    assign o_res.dist_out   = c_d[DW];
    assign o_res.seg_length = c_s[DW];
    assign o_res.mid_x      = sum_x[COORD_BITS:1];
    assign o_res.mid_y      = sum_y[COORD_BITS:1];
endmodule
